[src/sdcs_pkg.sv]
// Shared types and constants for the servo drive command shaper.
// No dependencies; used by every module in src.
package sdcs_pkg;

   localparam int unsigned TimeW = 48;
   localparam int unsigned DvdW  = 43;
   localparam int unsigned DvsW  = 16;
   localparam int unsigned MagW  = 43;
   localparam int unsigned M100W = 50;

   // flag bit positions in the stored flag word
   localparam int unsigned FlOc    = 0;
   localparam int unsigned FlPort  = 1;
   localparam int unsigned FlStbd  = 2;
   localparam int unsigned FlMaxr  = 3;
   localparam int unsigned FlMinr  = 4;
   localparam int unsigned FlOther = 5;

   localparam logic [1:0] KIND_COMMAND   = 2'd0;
   localparam logic [1:0] KIND_RESET     = 2'd1;
   localparam logic [1:0] KIND_DISENGAGE = 2'd2;
   localparam logic [1:0] KIND_PARAMS    = 2'd3;

   localparam logic [2:0] MODE_IDLE  = 3'd0;
   localparam logic [2:0] MODE_BRAKE = 3'd1;
   localparam logic [2:0] MODE_PORT  = 3'd2;
   localparam logic [2:0] MODE_STBD  = 3'd3;
   localparam logic [2:0] MODE_STOP  = 3'd4;

   localparam logic [1:0] DIR_NONE = 2'd0;
   localparam logic [1:0] DIR_PORT = 2'd1;
   localparam logic [1:0] DIR_STBD = 2'd2;

   localparam logic [2:0] REG_DRIVE_GAIN  = 3'd0;
   localparam logic [2:0] REG_COMP_VOLT   = 3'd1;
   localparam logic [2:0] REG_SPEED_MIN   = 3'd2;
   localparam logic [2:0] REG_SPEED_MAX   = 3'd3;
   localparam logic [2:0] REG_USE_BRAKE   = 3'd4;

   localparam logic [4:0] SYNC_WRAP = 5'd23;

   typedef struct packed {
      logic [47:0]        now_time;
      logic signed [15:0] command;
      logic               ap_enabled;
      logic [15:0]        supply_voltage;
      logic               flags_fresh;
      logic               flag_overcurrent;
      logic               flag_port_overcurrent;
      logic               flag_starboard_overcurrent;
      logic               flag_max_rudder;
      logic               flag_min_rudder;
      logic               flag_other_fault;
   } req_type;

   typedef struct packed {
      logic [1:0]         packet_kind;
      logic signed [15:0] command_value;
      logic [4:0]         param_sync;
      logic [1:0]         limit_multiplier;
      logic [2:0]         drive_mode;
      logic [15:0]        fault_total;
      logic               last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [15:0] cmd;
      logic [4:0]         sync;
      logic [1:0]         mul;
   } pkt_type;

endpackage

[src/servo_drive_command_shaper_top.sv]
// Servo drive command shaper: per-tick sequencer, output register, config registers.
// Depends on sdcs_pkg and sdcs_div.
//
// Usage: one req beat is one poll tick (time, command, enable, supply, fault flags).
// Each tick yields zero, one or two rsp beats; last_of_run marks the final beat of a
// tick. A tick that is blocked and rate limited yields no beat at all.
// The first rsp beat is presented from ST_EMIT, which a fault or disengage tick reaches
// from ST_EVAL, a blocked tick via ST_CHK, and a zero magnitude via ST_CHK and ST_FIN. A
// nonzero magnitude takes up to two passes of the shared bit-serial divider, each giving
// a 43-bit quotient: voltage compensation, then the speed mapping. One tick is in work at
// a time; req_stall stays high from acceptance until the last rsp beat of the tick has
// been loaded into the output register.
// The output register lets the next tick be accepted while the final beat still waits.
// When rsp_stall is high the output beat holds and the sequencer waits.
// The csr port writes configuration registers with no wait; write only while idle.
// Reset (synchronous, active high) restores register defaults, clears state and empties
// the output register. No clearing pass is needed.
module servo_drive_command_shaper_top (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  sdcs_pkg::req_type        req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output sdcs_pkg::rsp_type        rsp_data,
   input  logic                     csr_we,
   input  logic [2:0]               csr_index,
   input  logic [15:0]              csr_wdata
);
   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_EVAL = 9'b000000010,
      ST_CHK  = 9'b000000100,
      ST_DIV1 = 9'b000001000,
      ST_SCL  = 9'b000010000,
      ST_SCL2 = 9'b000100000,
      ST_DIV2 = 9'b001000000,
      ST_FIN  = 9'b010000000,
      ST_EMIT = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [15:0] gain_ff;
   logic        comp_ff;
   logic [6:0]  pmin_ff, pmax_ff;
   logic        brake_ff;

   // block state
   logic [1:0]  dir_ff, dir_in;
   logic        diseng_ff, diseng_in;
   logic        prev_ap_ff, prev_ap_in;
   logic [4:0]  sync_ff, sync_in;
   logic [47:0] lat_ff, lat_in;
   logic [47:0] lzt_ff, lzt_in;
   logic [15:0] fc_ff, fc_in;
   logic [5:0]  flags_ff, flags_in;

   // per-tick work registers
   sdcs_pkg::req_type                 in_ff, in_in;
   logic [sdcs_pkg::MagW-1:0]         mag_ff, mag_in;
   logic [sdcs_pkg::M100W-1:0]        acc_ff, acc_in;
   logic                              neg_ff, neg_in;
   logic [14:0]                       q_ff, q_in;
   logic [2:0]                        mode_ff, mode_in;
   logic [1:0]                        n_ff, n_in;
   logic [1:0]                        e_ff, e_in;
   sdcs_pkg::pkt_type                 pkt_ff [2];
   sdcs_pkg::pkt_type                 pkt_in [2];

   // output register
   logic                              rsp_valid_ff, rsp_valid_in;
   sdcs_pkg::rsp_type                 rsp_ff, rsp_in;

   // divider hookup
   logic                              div_start;
   logic [sdcs_pkg::DvdW-1:0]         div_dividend;
   logic [sdcs_pkg::DvsW-1:0]         div_divisor;
   logic                              div_done;
   logic [sdcs_pkg::DvdW-1:0]         div_quot;

   sdcs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   // zero-command rate limit, shared by every path that sends a zero
   logic        zc_ok;
   logic [6:0]  pmin_eff, pmax_eff;
   logic [16:0] abs_cmd;
   logic [32:0] prod;
   logic [sdcs_pkg::M100W-1:0] m100;
   logic [sdcs_pkg::M100W-1:0] pmin_sh, pmax_sh;
   logic        sides;

   assign zc_ok = ({1'b0, in_ff.now_time} <= ({1'b0, lat_ff} + 49'd1000000))
                  || ((in_ff.now_time - lzt_ff) >= 48'd200000);
   assign pmin_eff = (pmin_ff > 7'd100) ? 7'd100 : pmin_ff;
   assign pmax_eff = (pmax_ff > 7'd100) ? 7'd100 : pmax_ff;
   assign abs_cmd  = in_ff.command[15] ? (17'd0 - {in_ff.command[15], in_ff.command})
                                       : {1'b0, in_ff.command};
   assign prod     = abs_cmd * gain_ff;
   assign m100     = acc_ff + {5'd0, mag_ff, 2'b00};
   assign pmin_sh  = {16'd0, pmin_eff, 27'd0};
   assign pmax_sh  = {16'd0, pmax_eff, 27'd0};
   assign sides    = flags_ff[sdcs_pkg::FlPort] | flags_ff[sdcs_pkg::FlStbd];

   always_comb begin
      logic        use_pct;
      logic [6:0]  p;
      logic        above;
      logic        nz;
      logic        slot;
      logic [8:0]  span;

      state_in     = state_ff;
      dir_in       = dir_ff;
      diseng_in    = diseng_ff;
      prev_ap_in   = prev_ap_ff;
      sync_in      = sync_ff;
      lat_in       = lat_ff;
      lzt_in       = lzt_ff;
      fc_in        = fc_ff;
      flags_in     = flags_ff;
      in_in        = in_ff;
      mag_in       = mag_ff;
      acc_in       = acc_ff;
      neg_in       = neg_ff;
      q_in         = q_ff;
      mode_in      = mode_ff;
      n_in         = n_ff;
      e_in         = e_ff;
      pkt_in[0]    = pkt_ff[0];
      pkt_in[1]    = pkt_ff[1];
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      use_pct      = 1'b0;
      p            = '0;
      above        = 1'b0;
      nz           = mag_ff != '0;
      slot         = 1'b0;
      span         = 9'd0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               in_in = req_data;
               if (req_data.flags_fresh) begin
                  flags_in = {req_data.flag_other_fault, req_data.flag_min_rudder,
                              req_data.flag_max_rudder, req_data.flag_starboard_overcurrent,
                              req_data.flag_port_overcurrent, req_data.flag_overcurrent};
               end
               n_in     = 2'd0;
               e_in     = 2'd0;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (flags_ff[sdcs_pkg::FlOc] || flags_ff[sdcs_pkg::FlOther]) begin
               if (!sides && fc_ff != 16'hFFFF) begin
                  fc_in = fc_ff + 16'd1;
               end
               if (flags_ff[sdcs_pkg::FlOc]) begin
                  if (dir_ff == sdcs_pkg::DIR_PORT) begin
                     flags_in[sdcs_pkg::FlPort] = 1'b1;
                     flags_in[sdcs_pkg::FlStbd] = 1'b0;
                  end else if (dir_ff == sdcs_pkg::DIR_STBD) begin
                     flags_in[sdcs_pkg::FlStbd] = 1'b1;
                     flags_in[sdcs_pkg::FlPort] = 1'b0;
                  end
               end
               pkt_in[0] = '{sdcs_pkg::KIND_RESET, 16'sd0, 5'd0, 2'd0};
               n_in      = 2'd1;
               if (zc_ok) begin
                  pkt_in[1] = '{sdcs_pkg::KIND_COMMAND, 16'sd0, 5'd0, 2'd0};
                  n_in      = 2'd2;
                  lzt_in    = in_ff.now_time;
               end
               dir_in   = sdcs_pkg::DIR_NONE;
               mode_in  = sdcs_pkg::MODE_STOP;
               state_in = ST_EMIT;
            end else if (!in_ff.ap_enabled && in_ff.command == 16'sd0) begin
               diseng_in = 1'b1;
               pkt_in[0] = '{sdcs_pkg::KIND_PARAMS, 16'sd0, sync_ff, 2'd1};
               sync_in   = (sync_ff + 5'd1 == sdcs_pkg::SYNC_WRAP) ? 5'd0 : sync_ff + 5'd1;
               pkt_in[1] = '{sdcs_pkg::KIND_DISENGAGE, 16'sd0, 5'd0, 2'd0};
               n_in      = 2'd2;
               mode_in   = sdcs_pkg::MODE_IDLE;
               state_in  = ST_EMIT;
            end else begin
               diseng_in = 1'b0;
               mag_in    = {10'd0, prod};
               neg_in    = in_ff.command[15];
               state_in  = ST_CHK;
            end
         end
         ST_CHK: begin
            if ((nz && !neg_ff && (flags_ff[sdcs_pkg::FlPort] || flags_ff[sdcs_pkg::FlMaxr]))
                || (nz && neg_ff && (flags_ff[sdcs_pkg::FlStbd] || flags_ff[sdcs_pkg::FlMinr])))
            begin
               if (zc_ok) begin
                  pkt_in[0] = '{sdcs_pkg::KIND_COMMAND, 16'sd0, 5'd0, 2'd0};
                  n_in      = 2'd1;
                  lzt_in    = in_ff.now_time;
               end
               dir_in   = sdcs_pkg::DIR_NONE;
               mode_in  = sdcs_pkg::MODE_STOP;
               state_in = ST_EMIT;
            end else if (!nz) begin
               q_in     = '0;
               state_in = ST_FIN;
            end else if (comp_ff && in_ff.supply_voltage != 16'd0) begin
               // m * 3072 / v, rounded half up
               div_start    = 1'b1;
               div_dividend = (mag_ff << 11) + (mag_ff << 10)
                              + {28'd0, in_ff.supply_voltage[15:1]};
               div_divisor  = in_ff.supply_voltage;
               state_in     = ST_DIV1;
            end else begin
               state_in = ST_SCL;
            end
         end
         ST_DIV1: begin
            if (div_done) begin
               mag_in   = (div_quot == '0) ? {{(sdcs_pkg::MagW-1){1'b0}}, 1'b1} : div_quot;
               state_in = ST_SCL;
            end
         end
         ST_SCL: begin
            acc_in   = {1'b0, mag_ff, 6'd0} + {2'd0, mag_ff, 5'd0};
            state_in = ST_SCL2;
         end
         ST_SCL2: begin
            if (m100 < pmin_sh) begin
               use_pct = 1'b1;
               p       = pmin_eff;
            end
            above = use_pct ? (p > pmax_eff) : (m100 > pmax_sh);
            if (above) begin
               use_pct = 1'b1;
               p       = pmax_eff;
            end
            if (use_pct && p == 7'd0) begin
               q_in     = '0;
               state_in = ST_FIN;
            end else begin
               div_start = 1'b1;
               if (use_pct) begin
                  span         = 9'd100 + {p, 2'b00};
                  div_dividend = {19'd0, span, 15'd0} + 43'd250;
                  div_divisor  = 16'd500;
               end else begin
                  div_dividend = 43'd134217728 + (mag_ff << 2) + 43'd10240;
                  div_divisor  = 16'd20480;
               end
               state_in = ST_DIV2;
            end
         end
         ST_DIV2: begin
            if (div_done) begin
               q_in     = (div_quot > 43'd32767) ? 15'h7FFF : div_quot[14:0];
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (q_ff == '0) begin
               if (zc_ok) begin
                  pkt_in[0] = '{sdcs_pkg::KIND_COMMAND, 16'sd0, 5'd0, 2'd0};
                  slot      = 1'b1;
                  lzt_in    = in_ff.now_time;
               end
               mode_in = brake_ff ? sdcs_pkg::MODE_BRAKE : sdcs_pkg::MODE_IDLE;
            end else begin
               lat_in = in_ff.now_time;
               if (!neg_ff) begin
                  dir_in  = sdcs_pkg::DIR_PORT;
                  mode_in = sdcs_pkg::MODE_PORT;
               end else begin
                  dir_in  = sdcs_pkg::DIR_STBD;
                  mode_in = sdcs_pkg::MODE_STBD;
               end
               pkt_in[0] = '{sdcs_pkg::KIND_COMMAND,
                             neg_ff ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff}),
                             5'd0, 2'd0};
               slot = 1'b1;
            end
            pkt_in[slot] = '{sdcs_pkg::KIND_PARAMS, 16'sd0, sync_ff, sides ? 2'd2 : 2'd1};
            sync_in      = (sync_ff + 5'd1 == sdcs_pkg::SYNC_WRAP) ? 5'd0 : sync_ff + 5'd1;
            n_in         = {1'b0, slot} + 2'd1;
            if (in_ff.ap_enabled != prev_ap_ff) begin
               prev_ap_in                 = in_ff.ap_enabled;
               flags_in[sdcs_pkg::FlPort] = 1'b0;
               flags_in[sdcs_pkg::FlStbd] = 1'b0;
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (n_ff == 2'd0) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{pkt_ff[e_ff[0]].kind, pkt_ff[e_ff[0]].cmd, pkt_ff[e_ff[0]].sync,
                          pkt_ff[e_ff[0]].mul, mode_ff, fc_ff, (e_ff + 2'd1 == n_ff)};
               e_in = e_ff + 2'd1;
               if (e_ff + 2'd1 == n_ff) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gain_ff      <= 16'd4096;
         comp_ff      <= 1'b0;
         pmin_ff      <= 7'd0;
         pmax_ff      <= 7'd100;
         brake_ff     <= 1'b0;
         dir_ff       <= sdcs_pkg::DIR_NONE;
         diseng_ff    <= 1'b0;
         prev_ap_ff   <= 1'b0;
         sync_ff      <= '0;
         lat_ff       <= '0;
         lzt_ff       <= '0;
         fc_ff        <= '0;
         flags_ff     <= '0;
         n_ff         <= '0;
         e_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dir_ff       <= dir_in;
         diseng_ff    <= diseng_in;
         prev_ap_ff   <= prev_ap_in;
         sync_ff      <= sync_in;
         lat_ff       <= lat_in;
         lzt_ff       <= lzt_in;
         fc_ff        <= fc_in;
         flags_ff     <= flags_in;
         n_ff         <= n_in;
         e_ff         <= e_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               sdcs_pkg::REG_DRIVE_GAIN: gain_ff  <= csr_wdata;
               sdcs_pkg::REG_COMP_VOLT:  comp_ff  <= csr_wdata[0];
               sdcs_pkg::REG_SPEED_MIN:  pmin_ff  <= csr_wdata[6:0];
               sdcs_pkg::REG_SPEED_MAX:  pmax_ff  <= csr_wdata[6:0];
               sdcs_pkg::REG_USE_BRAKE:  brake_ff <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
      in_ff     <= in_in;
      mag_ff    <= mag_in;
      acc_ff    <= acc_in;
      neg_ff    <= neg_in;
      q_ff      <= q_in;
      mode_ff   <= mode_in;
      pkt_ff[0] <= pkt_in[0];
      pkt_ff[1] <= pkt_in[1];
      rsp_ff    <= rsp_in;
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_accept_eval: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == ST_EVAL)
      else $error("accepted beat did not start evaluation");
   a_sync_range: assert property (@(posedge clock) disable iff (reset)
      sync_ff < sdcs_pkg::SYNC_WRAP)
      else $error("sync counter out of range");
   a_sync_only_params: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.packet_kind != sdcs_pkg::KIND_PARAMS |-> rsp_data.param_sync == 5'd0)
      else $error("sync index on a non-parameter beat");
   a_div_in_div_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV1 || state_ff == ST_DIV2))
      else $error("divider finished outside a divide state");
`endif
endmodule

[src/sdcs_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
// Uses sdcs_pkg for operand widths.
module sdcs_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [sdcs_pkg::DvdW-1:0]    dividend,
   input  logic [sdcs_pkg::DvsW-1:0]    divisor,
   output logic                         done,
   output logic [sdcs_pkg::DvdW-1:0]    quotient
);
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [5:0]                  cnt_ff, cnt_in;
   logic [sdcs_pkg::DvdW-1:0]   dvd_ff, dvd_in;
   logic [sdcs_pkg::DvsW-1:0]   rem_ff, rem_in;
   logic [sdcs_pkg::DvsW-1:0]   dvs_ff, dvs_in;
   logic [sdcs_pkg::DvsW:0]     trial;
   logic [sdcs_pkg::DvsW:0]     diff;
   logic                        ge;

   assign trial = {rem_ff, dvd_ff[sdcs_pkg::DvdW-1]};
   assign ge    = trial >= {1'b0, dvs_ff};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // shift one dividend bit in, keep the quotient bit in its place
         rem_in = ge ? diff[sdcs_pkg::DvsW-1:0] : trial[sdcs_pkg::DvsW-1:0];
         dvd_in = {dvd_ff[sdcs_pkg::DvdW-2:0], ge};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(sdcs_pkg::DvdW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;
endmodule
